[rtl/rsbs_pkg.sv]
// Shared types and constants of the record sort unit.
package rsbs_pkg;

  localparam int unsigned MaxRecords = 64;
  localparam int unsigned IdxW       = $clog2(MaxRecords);
  localparam int unsigned CntW       = $clog2(MaxRecords + 1);

  localparam int unsigned TagW  = 6;
  localparam int unsigned CodeW = 56;
  localparam int unsigned AmtW  = 32;
  localparam int unsigned SumW  = AmtW + 1;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [CodeW-1:0] code;
    logic [AmtW-1:0]  salary;
    logic [AmtW-1:0]  allowance;
  } rec_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    rec_t            wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/rsbs_rec_mem.sv]
// Record store: one write port and one registered read port.
module rsbs_rec_mem (
  input  logic              clk_i,
  input  rsbs_pkg::mem_req_t req_i,
  output rsbs_pkg::rec_t    rdata_o
);

  rsbs_pkg::rec_t mem_q [rsbs_pkg::MaxRecords];
  rsbs_pkg::rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rsbs_sum_cmp.sv]
// Shared sum and compare unit: forms salary plus allowance and tests it against a held sum.
module rsbs_sum_cmp (
  input  rsbs_pkg::rec_t              rec_i,
  input  logic [rsbs_pkg::SumW-1:0]   ref_sum_i,
  output logic [rsbs_pkg::SumW-1:0]   sum_o,
  output logic                        ref_less_o
);

  assign sum_o      = {1'b0, rec_i.salary} + {1'b0, rec_i.allowance};
  assign ref_less_o = (ref_sum_i < sum_o);

endmodule

[rtl/record_sort_by_sum_descending_unit.sv]
// Record sort unit: loads records, sorts them by descending sum, streams them out.
//
// Usage: present one record on the input ports with start_i high while busy_o
// is low; the transfer happens at that clock edge. Records are stored in order
// until one arrives with last_record_i set. Records past the 64-entry capacity
// are dropped and the run reports overflow_flag_o high on every result.
// busy_o stays low while records are loaded.
// After the last record busy_o goes high while one shared sum/compare unit
// and a record memory with one write and one registered read port perform
// the exchange sort: position i is held in a register and compared with each
// later entry, one compare per cycle. For each position the sequencer reads
// it, loads it into that register, scans the later entries and writes it
// back. The results then leave one per cycle, each marked by done_o for
// exactly one cycle, out_last_o on the final one; the receiver cannot stall.
// busy_o falls as the final result is on the ports, and a new load may begin
// in that cycle.
// Reset clears the record count, the drop flag and the sequencer; the memory
// contents are not cleared.
module record_sort_by_sum_descending_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rsbs_pkg::TagW-1:0]      record_tag_i,
  input  logic [rsbs_pkg::CodeW-1:0]     code_chars_i,
  input  logic [rsbs_pkg::AmtW-1:0]      salary_cents_i,
  input  logic [rsbs_pkg::AmtW-1:0]      allowance_cents_i,
  input  logic                           last_record_i,
  output logic                           done_o,
  output logic [rsbs_pkg::TagW-1:0]      out_tag_o,
  output logic [rsbs_pkg::CodeW-1:0]     out_code_o,
  output logic [rsbs_pkg::AmtW-1:0]      out_salary_o,
  output logic [rsbs_pkg::AmtW-1:0]      out_allowance_o,
  output logic                           out_last_o,
  output logic                           overflow_flag_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD_I = 6'b000010,
    ST_LD_I = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_WR_I = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [rsbs_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      drop_q, drop_d;
  logic [rsbs_pkg::IdxW-1:0] i_q, i_d;
  logic [rsbs_pkg::IdxW-1:0] j_q, j_d;
  logic [rsbs_pkg::IdxW-1:0] p_q, p_d;
  logic                      done_q, done_d;
  logic                      last_q, last_d;
  logic                      ovf_q, ovf_d;

  rsbs_pkg::rec_t            cur_q, cur_d;
  logic [rsbs_pkg::SumW-1:0] cur_sum_q, cur_sum_d;

  rsbs_pkg::mem_req_t        mem_req;
  rsbs_pkg::rec_t            rd_rec;
  logic [rsbs_pkg::SumW-1:0] rd_sum;
  logic                      cur_less;

  logic                      accept;
  rsbs_pkg::rec_t            in_rec;

  rsbs_rec_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rd_rec)
  );

  rsbs_sum_cmp u_cmp (
    .rec_i      (rd_rec),
    .ref_sum_i  (cur_sum_q),
    .sum_o      (rd_sum),
    .ref_less_o (cur_less)
  );

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  assign in_rec.tag       = record_tag_i;
  assign in_rec.code      = code_chars_i;
  assign in_rec.salary    = salary_cents_i;
  assign in_rec.allowance = allowance_cents_i;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    i_d       = i_q;
    j_d       = j_q;
    p_d       = p_q;
    done_d    = 1'b0;
    last_d    = 1'b0;
    ovf_d     = ovf_q;
    cur_d     = cur_q;
    cur_sum_d = cur_sum_q;
    mem_req   = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cnt_q < rsbs_pkg::CntW'(rsbs_pkg::MaxRecords)) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = cnt_q[rsbs_pkg::IdxW-1:0];
            mem_req.wdata = in_rec;
            cnt_d         = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (last_record_i) begin
            i_d     = '0;
            state_d = ST_RD_I;
          end
        end
      end

      ST_RD_I: begin
        // fetch position i, or go straight to output once no later entry remains
        if ((rsbs_pkg::CntW'(i_q) + 1'b1) < cnt_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = i_q;
          state_d       = ST_LD_I;
        end else begin
          p_d     = '0;
          state_d = ST_EMIT;
        end
      end

      ST_LD_I: begin
        cur_d         = rd_rec;
        cur_sum_d     = rd_sum;
        j_d           = i_q + 1'b1;
        mem_req.re    = 1'b1;
        mem_req.raddr = i_q + 1'b1;
        state_d       = ST_SCAN;
      end

      ST_SCAN: begin
        // rd_rec holds entry j; swap it with the held record when its sum is larger
        if (cur_less) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = j_q;
          mem_req.wdata = cur_q;
          cur_d         = rd_rec;
          cur_sum_d     = rd_sum;
        end
        if ((rsbs_pkg::CntW'(j_q) + 1'b1) < cnt_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = j_q + 1'b1;
          j_d           = j_q + 1'b1;
        end else begin
          state_d = ST_WR_I;
        end
      end

      ST_WR_I: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_q;
        mem_req.wdata = cur_q;
        i_d           = i_q + 1'b1;
        state_d       = ST_RD_I;
      end

      ST_EMIT: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = p_q;
        done_d        = 1'b1;
        ovf_d         = drop_q;
        if ((rsbs_pkg::CntW'(p_q) + 1'b1) == cnt_q) begin
          last_d  = 1'b1;
          cnt_d   = '0;
          drop_d  = 1'b0;
          state_d = ST_IDLE;
        end else begin
          p_d = p_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
      done_q  <= 1'b0;
      last_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
      done_q  <= done_d;
      last_q  <= last_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cur_sum_q <= cur_sum_d;
  end

  assign done_o          = done_q;
  assign out_tag_o       = rd_rec.tag;
  assign out_code_o      = rd_rec.code;
  assign out_salary_o    = rd_rec.salary;
  assign out_allowance_o = rd_rec.allowance;
  assign out_last_o      = last_q;
  assign overflow_flag_o = ovf_q;

endmodule
